[design/ghtc_pkg.sv]
`timescale 1ns / 1ps

package ghtc_pkg;

   localparam int ANGLE_W    = 12;
   localparam int DUTY_W     = 10;
   localparam int TICKS_W    = 16;
   localparam int BAND_W     = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // One full turn and half a turn, in tenths of a degree.
   localparam logic [ANGLE_W:0]   ANGLE_FULL = 13'd3600;
   localparam logic [ANGLE_W-1:0] ANGLE_HALF = 12'd1800;

   localparam logic [DUTY_W-1:0]  COARSE_DUTY_RESET = 10'd100;
   localparam logic [DUTY_W-1:0]  FINE_DUTY_RESET   = 10'd51;
   localparam logic [TICKS_W-1:0] SETTLE_RESET      = 16'd200;
   localparam logic [TICKS_W-1:0] PAUSE_RESET       = 16'd150;
   localparam logic [BAND_W-1:0]  COARSE_BAND_RESET = 11'd150;
   localparam logic [BAND_W-1:0]  FINE_BAND_RESET   = 11'd10;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_LEFT  = 2'd1,
      REQ_RIGHT = 2'd2,
      REQ_ABS   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      DRV_STOP  = 2'd0,
      DRV_LEFT  = 2'd1,
      DRV_RIGHT = 2'd2
   } drive_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COARSE_DUTY_L = 3'd0,
      CSR_COARSE_DUTY_R = 3'd1,
      CSR_FINE_DUTY_L   = 3'd2,
      CSR_FINE_DUTY_R   = 3'd3,
      CSR_SETTLE_TICKS  = 3'd4,
      CSR_PAUSE_TICKS   = 3'd5,
      CSR_COARSE_BAND   = 3'd6,
      CSR_FINE_BAND     = 3'd7
   } csr_index_type;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_SETTLE = 5'b00010,
      PH_COARSE = 5'b00100,
      PH_PAUSE  = 5'b01000,
      PH_FINE   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [ANGLE_W-1:0] turn_angle;
      logic [ANGLE_W-1:0] yaw_sample;
   } req_item_type;

   typedef struct packed {
      logic [1:0]        drive_mode;
      logic [DUTY_W-1:0] left_duty;
      logic [DUTY_W-1:0] right_duty;
      logic              busy_res;
      logic              done_res;
   } rsp_item_type;

   typedef struct packed {
      logic [DUTY_W-1:0]  coarse_duty_left;
      logic [DUTY_W-1:0]  coarse_duty_right;
      logic [DUTY_W-1:0]  fine_duty_left;
      logic [DUTY_W-1:0]  fine_duty_right;
      logic [TICKS_W-1:0] settle_ticks;
      logic [TICKS_W-1:0] pause_ticks;
      logic [BAND_W-1:0]  coarse_band;
      logic [BAND_W-1:0]  fine_band;
   } cfg_type;

   // Circular error: neg and pos give the sign, mag the distance (at most half a turn).
   typedef struct packed {
      logic              neg;
      logic              pos;
      logic [BAND_W-1:0] mag;
   } err_type;

   function automatic logic [ANGLE_W-1:0] wrap_angle(input logic [ANGLE_W-1:0] v);
      logic [ANGLE_W:0] d;
      d = {1'b0, v} - ANGLE_FULL;
      if ({1'b0, v} >= ANGLE_FULL) begin
         return d[ANGLE_W-1:0];
      end
      return v;
   endfunction

   // Both operands must be at most one full turn, and not both equal to it.
   function automatic logic [ANGLE_W-1:0] add_mod(input logic [ANGLE_W-1:0] a,
                                                  input logic [ANGLE_W-1:0] b);
      logic [ANGLE_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= ANGLE_FULL) begin
         s = s - ANGLE_FULL;
      end
      return s[ANGLE_W-1:0];
   endfunction

endpackage

[design/ghtc_csr.sv]
`timescale 1ns / 1ps

module ghtc_csr import ghtc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_COARSE_DUTY_L: cfg_in.coarse_duty_left  = csr_wdata[DUTY_W-1:0];
            CSR_COARSE_DUTY_R: cfg_in.coarse_duty_right = csr_wdata[DUTY_W-1:0];
            CSR_FINE_DUTY_L:   cfg_in.fine_duty_left    = csr_wdata[DUTY_W-1:0];
            CSR_FINE_DUTY_R:   cfg_in.fine_duty_right   = csr_wdata[DUTY_W-1:0];
            CSR_SETTLE_TICKS:  cfg_in.settle_ticks      = csr_wdata[TICKS_W-1:0];
            CSR_PAUSE_TICKS:   cfg_in.pause_ticks       = csr_wdata[TICKS_W-1:0];
            CSR_COARSE_BAND:   cfg_in.coarse_band       = csr_wdata[BAND_W-1:0];
            CSR_FINE_BAND:     cfg_in.fine_band         = csr_wdata[BAND_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coarse_duty_left  <= COARSE_DUTY_RESET;
         cfg_ff.coarse_duty_right <= COARSE_DUTY_RESET;
         cfg_ff.fine_duty_left    <= FINE_DUTY_RESET;
         cfg_ff.fine_duty_right   <= FINE_DUTY_RESET;
         cfg_ff.settle_ticks      <= SETTLE_RESET;
         cfg_ff.pause_ticks       <= PAUSE_RESET;
         cfg_ff.coarse_band       <= COARSE_BAND_RESET;
         cfg_ff.fine_band         <= FINE_BAND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/ghtc_angle_err.sv]
`timescale 1ns / 1ps

module ghtc_angle_err import ghtc_pkg::*; (
   input  logic [ANGLE_W-1:0] target,
   input  logic [ANGLE_W-1:0] yaw,
   output err_type            err
);

   logic [ANGLE_W:0]   diff_raw;
   logic [ANGLE_W:0]   diff_sub;
   logic [ANGLE_W-1:0] diff;
   logic [ANGLE_W:0]   diff_neg;

   // Both angles are already below a full turn, so one subtraction wraps the difference.
   assign diff_raw = {1'b0, target} + ANGLE_FULL - {1'b0, yaw};
   assign diff_sub = diff_raw - ANGLE_FULL;
   assign diff     = (diff_raw >= ANGLE_FULL) ? diff_sub[ANGLE_W-1:0] : diff_raw[ANGLE_W-1:0];
   assign diff_neg = ANGLE_FULL - {1'b0, diff};

   assign err.neg = (diff > ANGLE_HALF);
   assign err.pos = (diff <= ANGLE_HALF) && (diff != '0);
   assign err.mag = err.neg ? diff_neg[BAND_W-1:0] : diff[BAND_W-1:0];

endmodule

[design/gyro_heading_turn_controller.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   req_item (req_type, turn_angle, yaw_sample)
// rsp_      out        rsp_valid/rsp_stall   rsp_item (drive_mode, duties, busy, done)
// csr_      in         csr_wr_en             csr_index, csr_wdata
//
// Every request beat gives exactly one response beat, registered in the response register.
// A new request can be taken every cycle unless the response stalls; the whole step is one
// pass from the input register through the angle error unit into the response register.
// Reset is synchronous and restores the idle phase and the register defaults.
// A stalled response holds its register, and the input register fills behind it before
// req_stall rises.

module gyro_heading_turn_controller import ghtc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_item,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;

   logic         s1_valid_ff;
   req_item_type s1_item_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;
   rsp_item_type rsp_item_in;

   phase_type          phase_ff, phase_in;
   logic [ANGLE_W-1:0] target_ff, target_in;
   logic [1:0]         pend_kind_ff, pend_kind_in;
   logic [ANGLE_W-1:0] pend_angle_ff, pend_angle_in;
   drive_type          dir_ff, dir_in;
   logic [TICKS_W-1:0] delay_ff, delay_in;

   logic               out_free;
   logic               fire;
   logic [ANGLE_W-1:0] yaw;
   logic [ANGLE_W-1:0] pend_angle;
   logic [ANGLE_W-1:0] new_target;
   logic               sampling;
   logic [ANGLE_W-1:0] err_target;
   err_type            err;
   logic [ANGLE_W:0]   right_step;

   ghtc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;

   assign yaw        = wrap_angle(s1_item_ff.yaw_sample);
   assign pend_angle = wrap_angle(pend_angle_ff);
   assign right_step = ANGLE_FULL - {1'b0, pend_angle};

   always_comb begin
      priority case (req_kind_type'(pend_kind_ff))
         REQ_LEFT:  new_target = add_mod(yaw, pend_angle);
         REQ_RIGHT: new_target = add_mod(yaw, right_step[ANGLE_W-1:0]);
         default:   new_target = pend_angle;
      endcase
   end

   // The start heading is sampled on the tick that ends the settle count.
   assign sampling   = (phase_ff == PH_SETTLE) && (delay_ff == '0);
   assign err_target = sampling ? new_target : target_ff;

   ghtc_angle_err u_err (
      .target (err_target),
      .yaw    (yaw),
      .err    (err)
   );

   always_comb begin
      logic      eval_coarse;
      logic      eval_fine;
      drive_type coarse_dir;

      eval_coarse   = 1'b0;
      eval_fine     = 1'b0;
      coarse_dir    = dir_ff;
      phase_in      = phase_ff;
      target_in     = target_ff;
      pend_kind_in  = pend_kind_ff;
      pend_angle_in = pend_angle_ff;
      dir_in        = dir_ff;
      delay_in      = delay_ff;

      rsp_item_in            = '0;
      rsp_item_in.drive_mode = DRV_STOP;
      rsp_item_in.busy_res   = 1'b1;

      unique case (phase_ff)
         PH_IDLE: begin
            if (req_kind_type'(s1_item_ff.req_type) != REQ_TICK) begin
               pend_kind_in  = s1_item_ff.req_type;
               pend_angle_in = s1_item_ff.turn_angle;
               delay_in      = cfg.settle_ticks;
               phase_in      = PH_SETTLE;
            end else begin
               rsp_item_in.busy_res = 1'b0;
            end
         end
         PH_SETTLE: begin
            if (delay_ff != '0) begin
               delay_in = delay_ff - 1'b1;
            end else begin
               target_in = new_target;
               priority case (req_kind_type'(pend_kind_ff))
                  REQ_LEFT:  coarse_dir = DRV_LEFT;
                  REQ_RIGHT: coarse_dir = DRV_RIGHT;
                  default:   coarse_dir = err.neg ? DRV_RIGHT : DRV_LEFT;
               endcase
               dir_in      = coarse_dir;
               eval_coarse = 1'b1;
            end
         end
         PH_COARSE: begin
            eval_coarse = 1'b1;
         end
         PH_PAUSE: begin
            if (delay_ff != '0) begin
               delay_in = delay_ff - 1'b1;
            end else begin
               eval_fine = 1'b1;
            end
         end
         PH_FINE: begin
            eval_fine = 1'b1;
         end
         default: begin
            phase_in             = PH_IDLE;
            rsp_item_in.busy_res = 1'b0;
         end
      endcase

      if (eval_coarse) begin
         if (err.mag > cfg.coarse_band) begin
            phase_in               = PH_COARSE;
            rsp_item_in.drive_mode = coarse_dir;
            rsp_item_in.left_duty  = cfg.coarse_duty_left;
            rsp_item_in.right_duty = cfg.coarse_duty_right;
         end else begin
            phase_in = PH_PAUSE;
            delay_in = cfg.pause_ticks;
         end
      end

      if (eval_fine) begin
         if (err.mag <= cfg.fine_band) begin
            phase_in             = PH_IDLE;
            dir_in               = DRV_STOP;
            rsp_item_in.busy_res = 1'b0;
            rsp_item_in.done_res = 1'b1;
         end else begin
            phase_in               = PH_FINE;
            rsp_item_in.drive_mode = err.pos ? DRV_LEFT : DRV_RIGHT;
            rsp_item_in.left_duty  = cfg.fine_duty_left;
            rsp_item_in.right_duty = cfg.fine_duty_right;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= PH_IDLE;
         target_ff     <= '0;
         pend_kind_ff  <= '0;
         pend_angle_ff <= '0;
         dir_ff        <= DRV_STOP;
         delay_ff      <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            s1_valid_ff <= 1'b1;
         end else if (fire) begin
            s1_valid_ff <= 1'b0;
         end

         if (fire) begin
            rsp_valid_ff  <= 1'b1;
            phase_ff      <= phase_in;
            target_ff     <= target_in;
            pend_kind_ff  <= pend_kind_in;
            pend_angle_ff <= pend_angle_in;
            dir_ff        <= dir_in;
            delay_ff      <= delay_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_item_ff <= req_item;
      end
      if (fire) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // A stopped drive never carries a duty.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_item_ff.drive_mode == DRV_STOP) |->
         (rsp_item_ff.left_duty == '0) && (rsp_item_ff.right_duty == '0))
      else $error("stop beat carries a nonzero duty");

   // The done beat closes the turn: the sequencer is idle right after it.
   assert property (@(posedge clock) disable iff (reset)
      fire && rsp_item_in.done_res |=> (phase_ff == PH_IDLE) && (dir_ff == DRV_STOP))
      else $error("done beat did not return the sequencer to idle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_item_ff.busy_res && rsp_item_ff.done_res))
      else $error("busy and done set in the same beat");

   // A pending count only ticks down by one per beat.
   assert property (@(posedge clock) disable iff (reset)
      fire && ((phase_ff == PH_SETTLE) || (phase_ff == PH_PAUSE)) && (delay_ff != '0) |=>
         (delay_ff == $past(delay_ff) - 1'b1) && (phase_ff == $past(phase_ff)))
      else $error("delay count did not step by one");

   // An idle tick leaves the sequencer idle and reports not busy.
   assert property (@(posedge clock) disable iff (reset)
      fire && (phase_ff == PH_IDLE) && (s1_item_ff.req_type == REQ_TICK) |=>
         (phase_ff == PH_IDLE) && rsp_valid_ff && !rsp_item_ff.busy_res)
      else $error("idle tick changed the sequencer");

endmodule

[tb/sv/heading_checker.sv]
`timescale 1ns / 1ps

module heading_checker import ghtc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_item_type          req_item,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_item_type          rsp_item,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    drives_due
);

   localparam int FULL_TURN = int'(ANGLE_FULL);
   localparam int HALF_TURN = FULL_TURN / 2;

   cfg_type      regs;
   phase_type    phase;
   int           target;
   req_kind_type held_kind;
   int           held_angle;
   drive_type    sweep_dir;
   int           ticks_left;
   rsp_item_type due_q[$];

   // Signed distance from yaw to goal, in (-half turn, half turn]; positive is to the left.
   function automatic int offset_to(input int goal, input int yaw);
      int d;
      d = (goal + FULL_TURN - yaw) % FULL_TURN;
      if (d > HALF_TURN) begin
         d = d - FULL_TURN;
      end
      return d;
   endfunction

   function automatic int magnitude(input int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic rsp_item_type drive_word(input drive_type mode,
                                               input logic [DUTY_W-1:0] l, r,
                                               input logic busy, done);
      rsp_item_type w;
      w.drive_mode = mode;
      w.left_duty  = (mode == DRV_STOP) ? '0 : l;
      w.right_duty = (mode == DRV_STOP) ? '0 : r;
      w.busy_res   = busy;
      w.done_res   = done;
      return w;
   endfunction

   // Advances the turn sequencer by one request beat and returns the drive it produces.
   function automatic rsp_item_type next_drive(input req_item_type beat);
      req_kind_type kind;
      int yaw;
      int a;
      int err;
      kind = req_kind_type'(beat.req_type);
      yaw  = int'(beat.yaw_sample) % FULL_TURN;

      if (kind != REQ_TICK && phase == PH_IDLE) begin
         held_kind  = kind;
         held_angle = int'(beat.turn_angle);
         ticks_left = int'(regs.settle_ticks);
         phase      = PH_SETTLE;
         return drive_word(DRV_STOP, '0, '0, 1'b1, 1'b0);
      end

      if (phase == PH_IDLE) begin
         return drive_word(DRV_STOP, '0, '0, 1'b0, 1'b0);
      end

      if (phase == PH_SETTLE) begin
         if (ticks_left != 0) begin
            ticks_left--;
            return drive_word(DRV_STOP, '0, '0, 1'b1, 1'b0);
         end
         a = held_angle % FULL_TURN;
         case (held_kind)
            REQ_LEFT: begin
               target    = (yaw + a) % FULL_TURN;
               sweep_dir = DRV_LEFT;
            end
            REQ_RIGHT: begin
               target    = (yaw + FULL_TURN - a) % FULL_TURN;
               sweep_dir = DRV_RIGHT;
            end
            default: begin
               target    = a;
               sweep_dir = (offset_to(a, yaw) >= 0) ? DRV_LEFT : DRV_RIGHT;
            end
         endcase
         phase = PH_COARSE;
      end

      if (phase == PH_COARSE) begin
         if (magnitude(offset_to(target, yaw)) > int'(regs.coarse_band)) begin
            return drive_word(sweep_dir, regs.coarse_duty_left, regs.coarse_duty_right,
                              1'b1, 1'b0);
         end
         phase      = PH_PAUSE;
         ticks_left = int'(regs.pause_ticks);
         return drive_word(DRV_STOP, '0, '0, 1'b1, 1'b0);
      end

      if (phase == PH_PAUSE) begin
         if (ticks_left != 0) begin
            ticks_left--;
            return drive_word(DRV_STOP, '0, '0, 1'b1, 1'b0);
         end
         phase = PH_FINE;
      end

      err = offset_to(target, yaw);
      if (magnitude(err) <= int'(regs.fine_band)) begin
         phase     = PH_IDLE;
         sweep_dir = DRV_STOP;
         return drive_word(DRV_STOP, '0, '0, 1'b0, 1'b1);
      end
      return drive_word((err > 0) ? DRV_LEFT : DRV_RIGHT, regs.fine_duty_left,
                        regs.fine_duty_right, 1'b1, 1'b0);
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         regs.coarse_duty_left  = COARSE_DUTY_RESET;
         regs.coarse_duty_right = COARSE_DUTY_RESET;
         regs.fine_duty_left    = FINE_DUTY_RESET;
         regs.fine_duty_right   = FINE_DUTY_RESET;
         regs.settle_ticks      = SETTLE_RESET;
         regs.pause_ticks       = PAUSE_RESET;
         regs.coarse_band       = COARSE_BAND_RESET;
         regs.fine_band         = FINE_BAND_RESET;
         phase          = PH_IDLE;
         target         = 0;
         held_kind      = REQ_TICK;
         held_angle     = 0;
         sweep_dir      = DRV_STOP;
         ticks_left     = 0;
         mismatch_count = 0;
         due_q.delete();
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (due_q.size() == 0) begin
               $error("response beat arrived with no request waiting for it");
               mismatch_count++;
            end else begin
               want = due_q.pop_front();
               if (rsp_item.drive_mode !== want.drive_mode) begin
                  $error("drive_mode: expected %0d, got %0d", want.drive_mode,
                         rsp_item.drive_mode);
                  mismatch_count++;
               end
               if (rsp_item.left_duty !== want.left_duty) begin
                  $error("left_duty: expected %0d, got %0d", want.left_duty,
                         rsp_item.left_duty);
                  mismatch_count++;
               end
               if (rsp_item.right_duty !== want.right_duty) begin
                  $error("right_duty: expected %0d, got %0d", want.right_duty,
                         rsp_item.right_duty);
                  mismatch_count++;
               end
               if (rsp_item.busy_res !== want.busy_res) begin
                  $error("busy_res: expected %0d, got %0d", want.busy_res,
                         rsp_item.busy_res);
                  mismatch_count++;
               end
               if (rsp_item.done_res !== want.done_res) begin
                  $error("done_res: expected %0d, got %0d", want.done_res,
                         rsp_item.done_res);
                  mismatch_count++;
               end
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            due_q.push_back(next_drive(req_item));
         end
         if (csr_wr_en === 1'b1) begin
            case (csr_index_type'(csr_index))
               CSR_COARSE_DUTY_L: regs.coarse_duty_left  = csr_wdata[DUTY_W-1:0];
               CSR_COARSE_DUTY_R: regs.coarse_duty_right = csr_wdata[DUTY_W-1:0];
               CSR_FINE_DUTY_L:   regs.fine_duty_left    = csr_wdata[DUTY_W-1:0];
               CSR_FINE_DUTY_R:   regs.fine_duty_right   = csr_wdata[DUTY_W-1:0];
               CSR_SETTLE_TICKS:  regs.settle_ticks      = csr_wdata[TICKS_W-1:0];
               CSR_PAUSE_TICKS:   regs.pause_ticks       = csr_wdata[TICKS_W-1:0];
               CSR_COARSE_BAND:   regs.coarse_band       = csr_wdata[BAND_W-1:0];
               CSR_FINE_BAND:     regs.fine_band         = csr_wdata[BAND_W-1:0];
               default: ;
            endcase
         end
      end
      drives_due = due_q.size();
   end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
   import ghtc_pkg::*;

   localparam int FULL_TURN = int'(ANGLE_FULL);

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_item_type          req_item;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_item_type          rsp_item;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatch_count;
   int drives_due;
   int burst_left;
   int beats_offered;
   int settle_now;
   int pause_now;
   int fine_now;

   gyro_heading_turn_controller u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   heading_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item       (rsp_item),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .drives_due     (drives_due)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      #80_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // The receiver stalls in short runs between free stretches, and once holds off long
   // enough for the block to back up into its request side.
   initial begin : receiver
      int free_len;
      int stall_len;
      int cycles_seen;
      int hold_at;
      bit held;
      rsp_stall   = 1'b0;
      cycles_seen = 0;
      held        = 1'b0;
      hold_at     = $urandom_range(100, 400);
      forever begin
         free_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(0, 20);
         stall_len = $urandom_range(1, 6);
         if (!held && cycles_seen >= hold_at) begin
            stall_len = 300;
            held      = 1'b1;
         end
         repeat (free_len) begin
            @(negedge clock);
            rsp_stall = 1'b0;
            cycles_seen++;
         end
         repeat (stall_len) begin
            @(negedge clock);
            rsp_stall = 1'b1;
            cycles_seen++;
         end
      end
   end

   // Offers one request beat and returns at the falling edge after it is taken.
   task automatic offer(input req_kind_type kind, input int ang, input int yaw);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      req_item.req_type   = kind;
      req_item.turn_angle = ang[ANGLE_W-1:0];
      req_item.yaw_sample = yaw[ANGLE_W-1:0];
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      beats_offered++;
      @(negedge clock);
   endtask

   task automatic set_reg(input csr_index_type idx, input int value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_SETTLE_TICKS: settle_now = value;
         CSR_PAUSE_TICKS:  pause_now  = value;
         CSR_FINE_BAND:    fine_now   = value;
         default: ;
      endcase
   endtask

   // Registers change only once every response is back and the pipeline has emptied.
   task automatic wait_drained();
      req_valid = 1'b0;
      while (drives_due != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // One full turn: start, settle at a steady yaw, sweep toward the target, pause, a few
   // fine corrections, then ticks parked on the target so that the turn always completes.
   // A rough turn mixes random yaw and ignored starts into the sweep.
   task automatic run_turn(input bit clean);
      req_kind_type kind;
      int ang;
      int a;
      int y0;
      int yw;
      int tgt;
      int span;
      int steps;
      int yaw;
      int spread;
      int n;
      bit go_left;
      case ($urandom_range(0, 2))
         0:       kind = REQ_LEFT;
         1:       kind = REQ_RIGHT;
         default: kind = REQ_ABS;
      endcase
      case ($urandom_range(0, 9))
         0:       ang = $urandom_range(3600, 4095);
         1:       ang = 0;
         2:       ang = 1800;
         3:       ang = 3599;
         default: ang = $urandom_range(0, 3599);
      endcase
      y0 = ($urandom_range(0, 9) == 0) ? $urandom_range(3600, 4095) : $urandom_range(0, 3599);
      a  = ang % FULL_TURN;
      yw = y0 % FULL_TURN;
      if (kind == REQ_LEFT) begin
         tgt     = (yw + a) % FULL_TURN;
         go_left = 1'b1;
      end else if (kind == REQ_RIGHT) begin
         tgt     = (yw + FULL_TURN - a) % FULL_TURN;
         go_left = 1'b0;
      end else begin
         tgt     = a;
         go_left = ((a - yw + FULL_TURN) % FULL_TURN) <= FULL_TURN / 2;
      end

      offer(kind, ang, $urandom_range(0, 4095));
      repeat (settle_now + 1) offer(REQ_TICK, $urandom_range(0, 4095), y0);

      span  = go_left ? (tgt - yw + FULL_TURN) % FULL_TURN : (yw - tgt + FULL_TURN) % FULL_TURN;
      steps = $urandom_range(1, 6);
      for (int k = 1; k <= steps; k++) begin
         yaw = go_left ? yw + span * k / steps : yw + FULL_TURN - span * k / steps;
         if (k == steps) begin
            yaw = yaw + $urandom_range(0, 60) - 30;
         end
         yaw = (yaw + 2 * FULL_TURN) % FULL_TURN;
         if (!clean && $urandom_range(0, 2) == 0) begin
            yaw = $urandom_range(0, 4095);
         end
         if (!clean && $urandom_range(0, 5) == 0) begin
            offer(req_kind_type'($urandom_range(1, 3)), $urandom_range(0, 4095), yaw);
         end else begin
            offer(REQ_TICK, $urandom_range(0, 4095), yaw);
         end
      end

      repeat (pause_now) offer(REQ_TICK, $urandom_range(0, 4095), $urandom_range(0, 4095));

      spread = fine_now + 40;
      n = $urandom_range(0, 4);
      repeat (n) begin
         yaw = (tgt + $urandom_range(0, 2 * spread) - spread + 2 * FULL_TURN) % FULL_TURN;
         offer(REQ_TICK, $urandom_range(0, 4095), yaw);
      end

      repeat ((pause_now > 1000) ? 2 : pause_now + 3) begin
         offer(REQ_TICK, $urandom_range(0, 4095), tgt);
      end
   endtask

   task automatic run_phase(input int p);
      int goal;
      int n;
      wait_drained();
      set_reg(CSR_COARSE_DUTY_L, (p == 0) ? 0 : (p == 1) ? 1023 : $urandom_range(0, 1023));
      set_reg(CSR_COARSE_DUTY_R, (p == 0) ? 1023 : (p == 1) ? 0 : $urandom_range(0, 1023));
      set_reg(CSR_FINE_DUTY_L, (p == 2) ? 1023 : (p == 3) ? 0 : $urandom_range(0, 1023));
      set_reg(CSR_FINE_DUTY_R, (p == 2) ? 0 : (p == 3) ? 1023 : $urandom_range(0, 1023));
      set_reg(CSR_SETTLE_TICKS, (p == 1) ? 0 : $urandom_range(0, 6));
      set_reg(CSR_PAUSE_TICKS, (p == 1) ? 0 : (p == 4) ? 40 : $urandom_range(0, 6));
      set_reg(CSR_COARSE_BAND, (p == 2) ? 0 : (p == 3) ? 2047 : (p == 4) ? 1800
                                                             : $urandom_range(0, 400));
      set_reg(CSR_FINE_BAND, (p == 2) ? 0 : (p == 3) ? 2047 : (p == 5) ? 1800
                                                         : $urandom_range(0, 60));
      goal = beats_offered + 140;
      while (beats_offered < goal) begin
         if ($urandom_range(0, 9) == 0) begin
            // Idle ticks between turns are ignored and do not count toward the phase.
            n = $urandom_range(1, 3);
            repeat (n) offer(REQ_TICK, $urandom_range(0, 4095), $urandom_range(0, 4095));
            beats_offered -= n;
         end else begin
            run_turn($urandom_range(0, 3) != 0);
         end
      end
   endtask

   initial begin
      int guard;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_item      = '0;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      burst_left    = 0;
      beats_offered = 0;
      settle_now    = int'(SETTLE_RESET);
      pause_now     = int'(PAUSE_RESET);
      fine_now      = int'(FINE_BAND_RESET);
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // One turn on the register defaults.
      offer(REQ_TICK, 4095, 4095);
      offer(REQ_TICK, 0, 0);
      run_turn(1'b1);

      wait_drained();
      set_reg(CSR_COARSE_DUTY_L, 1023);
      set_reg(CSR_COARSE_DUTY_R, 0);
      set_reg(CSR_FINE_DUTY_L, 1);
      set_reg(CSR_FINE_DUTY_R, 700);
      set_reg(CSR_SETTLE_TICKS, 1);
      set_reg(CSR_PAUSE_TICKS, 1);
      set_reg(CSR_COARSE_BAND, 100);
      set_reg(CSR_FINE_BAND, 5);

      // Left turn with a start arriving mid-turn, fine correction both ways, then done.
      offer(REQ_TICK, 4095, 4095);
      offer(REQ_LEFT, 900, 4095);
      offer(REQ_RIGHT, 0, 1000);
      offer(REQ_TICK, 0, 1000);
      offer(REQ_TICK, 0, 1850);
      offer(REQ_TICK, 0, 0);
      offer(REQ_TICK, 0, 1880);
      offer(REQ_TICK, 0, 1920);
      offer(REQ_TICK, 0, 1903);
      // Absolute heading exactly half a turn away goes left.
      offer(REQ_ABS, 1800, 0);
      offer(REQ_TICK, 0, 0);
      offer(REQ_TICK, 0, 0);
      offer(REQ_TICK, 0, 1795);
      offer(REQ_TICK, 0, 1795);
      offer(REQ_TICK, 0, 1800);
      // Out-of-range heading, already within the coarse band at sampling.
      offer(REQ_ABS, 4095, 123);
      offer(REQ_TICK, 0, 3000);
      offer(REQ_TICK, 0, 550);
      offer(REQ_TICK, 0, 550);
      offer(REQ_TICK, 0, 495);
      // Right turn by almost a full turn from an out-of-range yaw.
      offer(REQ_RIGHT, 3599, 0);
      offer(REQ_TICK, 0, 4000);
      offer(REQ_TICK, 0, 4000);
      offer(REQ_TICK, 0, 401);
      offer(REQ_TICK, 0, 401);

      for (int p = 0; p < 7; p++) begin
         run_phase(p);
      end

      // Longest delays last: a start that counts down from the top of the settle range.
      wait_drained();
      set_reg(CSR_COARSE_DUTY_L, $urandom_range(0, 1023));
      set_reg(CSR_COARSE_DUTY_R, $urandom_range(0, 1023));
      set_reg(CSR_FINE_DUTY_L, $urandom_range(0, 1023));
      set_reg(CSR_FINE_DUTY_R, $urandom_range(0, 1023));
      set_reg(CSR_SETTLE_TICKS, 65535);
      set_reg(CSR_PAUSE_TICKS, 65535);
      set_reg(CSR_COARSE_BAND, 200);
      set_reg(CSR_FINE_BAND, 20);
      offer(REQ_ABS, $urandom_range(0, 4095), $urandom_range(0, 4095));
      repeat (24) offer(REQ_TICK, $urandom_range(0, 4095), $urandom_range(0, 4095));

      req_valid = 1'b0;
      guard = 0;
      while (drives_due != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
      repeat (10) @(negedge clock);
      if (drives_due != 0) begin
         $error("%0d response beats never arrived", drives_due);
      end
      if (mismatch_count == 0 && drives_due == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
